// ===== hdl/qos_packet_steering_queues_macros.svh =====
// Assertion macros shared by the steering queue checkers.
// Included by the checker file; depends on nothing else.
`ifndef QOS_PACKET_STEERING_QUEUES_MACROS_SVH
`define QOS_PACKET_STEERING_QUEUES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define QPSQ_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("steering queue check failed");

// Consequent must hold in the cycle after the antecedent, outside reset.
`define QPSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("steering queue check failed");

// Consequent must hold in the cycle after the antecedent, reset included.
`define QPSQ_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("steering queue check failed");

`endif

// ===== hdl/qpsq_pkg.sv =====
// Types, codes and constants of the QoS packet steering queues.
// Used by the screen, the top level and the checker; depends on nothing.
`default_nettype none

package qpsq_pkg;

    // Field widths of the request and response.
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int CLASS_W = 2;
    localparam int CHK_W   = 16;
    localparam int TAG_W   = 8;
    localparam int VERD_W  = 4;
    localparam int QSEL_W  = 2;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W = 3;

    // Defaults of the top-level parameters.
    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int DEF_TAG_BITS    = 8;

    // Blacklist windows: base < source < base + REJECT_SPAN.
    localparam int unsigned NUM_WINDOWS = 4;
    localparam logic [ADDR_W-1:0] REJECT_SPAN = 32'd1048575;
    localparam logic [ADDR_W-1:0] BASE_RESET [NUM_WINDOWS] = '{
        32'h1000_0000, 32'h5000_0000, 32'h6000_0000, 32'hD000_0000
    };
    localparam logic [CHK_W-1:0] MARKER_RESET = 16'd1234;

    // Reject counters saturate here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam int NUM_COUNTERS = 5;
    localparam logic [2:0] CNT_SOURCE     = 3'd0;
    localparam logic [2:0] CNT_CHECK      = 3'd1;
    localparam logic [2:0] CNT_CLASS_BASE = 3'd2;

    // Queue numbers: three class queues and the overflow queue.
    localparam int NUM_QUEUES = 4;
    localparam logic [QSEL_W-1:0] Q_HIGH = 2'd0;
    localparam logic [QSEL_W-1:0] Q_OVF  = 2'd3;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ARRIVE  = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_VERIFY  = 2'd2
    } t_cmd;

    typedef enum logic [VERD_W-1:0] {
        V_QUEUED      = 4'd0,
        V_QUEUED_OVF  = 4'd1,
        V_BAD_SOURCE  = 4'd2,
        V_BAD_CHECK   = 4'd3,
        V_FULL_DROP   = 4'd4,
        V_UNKNOWN     = 4'd5,
        V_FORWARDED   = 4'd6,
        V_NONE        = 4'd7,
        V_MOVED       = 4'd8,
        V_OVF_EMPTY   = 4'd9
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_A = 3'd0,
        CFG_BASE_B = 3'd1,
        CFG_BASE_C = 3'd2,
        CFG_BASE_D = 3'd3,
        CFG_MARKER = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  source_addr;
        logic [CLASS_W-1:0] traffic_class;
        logic [CHK_W-1:0]   check_word;
        logic [TAG_W-1:0]   packet_tag;
    } t_req;

    typedef struct packed {
        t_verdict           verdict;
        logic [QSEL_W-1:0]  queue_sel;
        logic [TAG_W-1:0]   tag_out;
        logic [CLASS_W-1:0] class_out;
        logic [COUNT_W-1:0] cause_count;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [ADDR_W-1:0]    data;
    } t_cfg;

    // Screening verdict from the header filter.
    typedef struct packed {
        logic bad_source;
        logic bad_check;
    } t_screen;

endpackage

`default_nettype wire

// ===== hdl/qpsq_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Used for the request, response and configuration channels.
`default_nettype none

interface qpsq_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/qpsq_screen.sv =====
// Header screen: configuration registers, blacklist windows and check marker.
// Depends on qpsq_pkg and qpsq_chan_if.
`default_nettype none

module qpsq_screen (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qpsq_chan_if.sink                       i_cfg,
    input  logic [qpsq_pkg::ADDR_W-1:0]     i_source_addr,
    input  logic [qpsq_pkg::CHK_W-1:0]      i_check_word,
    output qpsq_pkg::t_screen               o_screen
);
    import qpsq_pkg::*;

    localparam int TOP_W = ADDR_W + 1;

    logic [ADDR_W-1:0] r_base   [NUM_WINDOWS];
    logic [TOP_W-1:0]  r_top    [NUM_WINDOWS];
    logic [CHK_W-1:0]  r_marker;
    logic [NUM_WINDOWS-1:0] w_hit;
    t_cfg              w_cfg;

    assign w_cfg       = i_cfg.payload;
    assign i_cfg.ready = 1'b1;

    // Register writes. The window top is kept precomputed, without wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WINDOWS; w++) begin
                r_base[w] <= BASE_RESET[w];
                r_top[w]  <= {1'b0, BASE_RESET[w]} + {1'b0, REJECT_SPAN};
            end
            r_marker <= MARKER_RESET;
        end else if (i_cfg.valid) begin
            unique case (w_cfg.index)
                CFG_BASE_A, CFG_BASE_B, CFG_BASE_C, CFG_BASE_D: begin
                    r_base[w_cfg.index[1:0]] <= w_cfg.data;
                    r_top[w_cfg.index[1:0]]  <= {1'b0, w_cfg.data} + {1'b0, REJECT_SPAN};
                end
                CFG_MARKER: begin
                    r_marker <= w_cfg.data[CHK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A source strictly inside any window is blacklisted.
    always_comb begin
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            w_hit[w] = (i_source_addr > r_base[w]) && ({1'b0, i_source_addr} < r_top[w]);
        end
    end

    assign o_screen.bad_source = |w_hit;
    assign o_screen.bad_check  = (i_check_word == r_marker);

endmodule

`default_nettype wire

// ===== hdl/qos_packet_steering_queues.sv =====
// QoS packet steering queues: three class queues and one overflow queue of
// packet tags. An arrival, a forward with all class queues empty, a verify
// with an empty overflow queue and an undefined command are answered from the
// idle state; a forward that pops a packet and a verify that pops the overflow
// head first wait in S_FWD or S_VFY for the registered queue memory read.
// Results sit in an output register; the next request is taken in the idle state
// once that register is empty or being emptied in the same cycle. Queue stores
// need no clearing after reset. Depends on qpsq_pkg, qpsq_chan_if, qpsq_screen.
`default_nettype none

module qos_packet_steering_queues #(
    parameter int QUEUE_DEPTH = qpsq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = qpsq_pkg::DEF_TAG_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qpsq_chan_if.sink   i_req,
    qpsq_chan_if.source o_rsp,
    qpsq_chan_if.sink   i_cfg
);
    import qpsq_pkg::*;

    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W    = FILL_W + 1;
    localparam int CA_W     = $clog2(3 * QUEUE_DEPTH);
    localparam int TAG_ST_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int OVF_W    = CLASS_W + TAG_ST_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FWD,
        S_VFY
    } t_state;

    function automatic logic [CA_W-1:0] class_addr(input logic [QSEL_W-1:0] q,
                                                   input logic [PTR_W-1:0] slot);
        return CA_W'(q) * CA_W'(QUEUE_DEPTH) + CA_W'(slot);
    endfunction

    t_req              w_req;
    t_screen           w_screen;
    logic              w_accept;
    logic [TAG_ST_W-1:0] w_tag_st;

    t_state            r_state, n_state;
    logic              r_rsp_valid;
    t_rsp              r_rsp, n_rsp;
    logic              w_load;
    logic [QSEL_W-1:0] r_q, n_q;

    // Queue memories.
    logic [TAG_ST_W-1:0] r_cls_mem [3 * QUEUE_DEPTH];
    logic [OVF_W-1:0]    r_ovf_mem [QUEUE_DEPTH];
    logic [TAG_ST_W-1:0] r_cls_rd;
    logic [OVF_W-1:0]    r_ovf_rd;
    logic                w_cls_we, w_ovf_we;
    logic [CA_W-1:0]     w_cls_wa, w_cls_ra;
    logic [PTR_W-1:0]    w_ovf_wa, w_ovf_ra;
    logic [TAG_ST_W-1:0] w_cls_wd;
    logic [OVF_W-1:0]    w_ovf_wd;

    // Queue pointers and fill levels.
    logic [PTR_W-1:0]  r_head [NUM_QUEUES];
    logic [FILL_W-1:0] r_fill [NUM_QUEUES];
    logic [PTR_W-1:0]  w_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] w_full, w_empty, w_push, w_pop;

    // Reject counters.
    logic [COUNT_W-1:0] r_cnt     [NUM_COUNTERS];
    logic [COUNT_W-1:0] w_cnt_sat [NUM_COUNTERS];
    logic               w_bump_en;
    logic [2:0]         w_bump_sel;

    logic [CLASS_W-1:0]  w_ec;
    logic [TAG_ST_W-1:0] w_et;
    logic [QSEL_W-1:0]   w_fq;

    assign w_req    = i_req.payload;
    assign w_accept = i_req.valid && i_req.ready;
    assign w_tag_st = w_req.packet_tag[TAG_ST_W-1:0];
    assign w_ec     = r_ovf_rd[OVF_W-1:TAG_ST_W];
    assign w_et     = r_ovf_rd[TAG_ST_W-1:0];

    assign i_req.ready   = (r_state == S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    qpsq_screen u_screen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .i_source_addr (w_req.source_addr),
        .i_check_word  (w_req.check_word),
        .o_screen      (w_screen)
    );

    // Per-queue status and pointer update.
    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        logic [SUM_W-1:0] w_sum;

        assign w_full[q]  = (r_fill[q] == FILL_W'(QUEUE_DEPTH));
        assign w_empty[q] = (r_fill[q] == '0);
        assign w_sum      = SUM_W'(r_head[q]) + SUM_W'(r_fill[q]);
        assign w_tail[q]  = (w_sum >= SUM_W'(QUEUE_DEPTH)) ?
                            PTR_W'(w_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(w_sum);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_head[q] <= '0;
                r_fill[q] <= '0;
            end else begin
                if (w_pop[q]) begin
                    r_head[q] <= (r_head[q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : r_head[q] + PTR_W'(1);
                end
                if (w_push[q] && !w_pop[q]) begin
                    r_fill[q] <= r_fill[q] + FILL_W'(1);
                end else if (w_pop[q] && !w_push[q]) begin
                    r_fill[q] <= r_fill[q] - FILL_W'(1);
                end
            end
        end
    end

    // Saturating reject counters.
    for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_count
        assign w_cnt_sat[k] = (r_cnt[k] == COUNT_MAX) ? r_cnt[k] : r_cnt[k] + COUNT_W'(1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[k] <= '0;
            end else if (w_bump_en && (w_bump_sel == 3'(k))) begin
                r_cnt[k] <= w_cnt_sat[k];
            end
        end
    end

    // Highest-priority non-empty class queue for a forward request.
    always_comb begin
        priority if (!w_empty[0]) begin
            w_fq = 2'd0;
        end else if (!w_empty[1]) begin
            w_fq = 2'd1;
        end else begin
            w_fq = 2'd2;
        end
    end

    // Command decode, queue access and result assembly.
    always_comb begin
        n_state   = r_state;
        n_q       = r_q;
        w_load    = 1'b0;
        w_cls_we  = 1'b0;
        w_cls_wa  = '0;
        w_cls_wd  = '0;
        w_cls_ra  = '0;
        w_ovf_we  = 1'b0;
        w_ovf_wa  = '0;
        w_ovf_wd  = '0;
        w_ovf_ra  = '0;
        w_push    = '0;
        w_pop     = '0;
        w_bump_en = 1'b0;
        w_bump_sel = CNT_SOURCE;
        n_rsp.verdict   = V_NONE;
        n_rsp.queue_sel = '0;
        n_rsp.tag_out   = '0;
        n_rsp.class_out = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req.cmd)
                        CMD_ARRIVE: begin
                            w_load          = 1'b1;
                            n_rsp.tag_out   = TAG_W'(w_tag_st);
                            n_rsp.class_out = w_req.traffic_class;
                            priority if (w_screen.bad_source) begin
                                n_rsp.verdict = V_BAD_SOURCE;
                                w_bump_en     = 1'b1;
                                w_bump_sel    = CNT_SOURCE;
                            end else if (w_screen.bad_check) begin
                                n_rsp.verdict = V_BAD_CHECK;
                                w_bump_en     = 1'b1;
                                w_bump_sel    = CNT_CHECK;
                            end else if (w_req.traffic_class == CLASS_UNKNOWN) begin
                                n_rsp.verdict = V_UNKNOWN;
                            end else if (!w_full[w_req.traffic_class]) begin
                                n_rsp.verdict   = V_QUEUED;
                                n_rsp.queue_sel = w_req.traffic_class;
                                w_cls_we = 1'b1;
                                w_cls_wa = class_addr(w_req.traffic_class,
                                                      w_tail[w_req.traffic_class]);
                                w_cls_wd = w_tag_st;
                                w_push[w_req.traffic_class] = 1'b1;
                            end else if (!w_full[Q_OVF]) begin
                                n_rsp.verdict   = V_QUEUED_OVF;
                                n_rsp.queue_sel = Q_OVF;
                                w_ovf_we = 1'b1;
                                w_ovf_wa = w_tail[Q_OVF];
                                w_ovf_wd = {w_req.traffic_class, w_tag_st};
                                w_push[Q_OVF] = 1'b1;
                            end else begin
                                n_rsp.verdict   = V_FULL_DROP;
                                n_rsp.queue_sel = w_req.traffic_class;
                                w_bump_en  = 1'b1;
                                w_bump_sel = CNT_CLASS_BASE + 3'(w_req.traffic_class);
                            end
                        end
                        CMD_FORWARD: begin
                            if (w_empty[0] && w_empty[1] && w_empty[2]) begin
                                w_load = 1'b1;
                            end else begin
                                w_cls_ra   = class_addr(w_fq, r_head[w_fq]);
                                w_pop[w_fq] = 1'b1;
                                n_q        = w_fq;
                                n_state    = S_FWD;
                            end
                        end
                        CMD_VERIFY: begin
                            if (w_empty[Q_OVF]) begin
                                w_load          = 1'b1;
                                n_rsp.verdict   = V_OVF_EMPTY;
                                n_rsp.queue_sel = Q_OVF;
                            end else begin
                                w_ovf_ra      = r_head[Q_OVF];
                                w_pop[Q_OVF]  = 1'b1;
                                n_state       = S_VFY;
                            end
                        end
                        default: begin
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_FWD: begin
                w_load          = 1'b1;
                n_rsp.verdict   = V_FORWARDED;
                n_rsp.queue_sel = r_q;
                n_rsp.tag_out   = TAG_W'(r_cls_rd);
                n_rsp.class_out = r_q;
                n_state         = S_IDLE;
            end
            S_VFY: begin
                w_load          = 1'b1;
                n_rsp.tag_out   = TAG_W'(w_et);
                n_rsp.class_out = w_ec;
                n_state         = S_IDLE;
                priority if (w_ec == CLASS_UNKNOWN) begin
                    n_rsp.verdict   = V_UNKNOWN;
                    n_rsp.queue_sel = Q_OVF;
                end else if (!w_full[w_ec]) begin
                    n_rsp.verdict   = V_MOVED;
                    n_rsp.queue_sel = w_ec;
                    w_cls_we  = 1'b1;
                    w_cls_wa  = class_addr(w_ec, w_tail[w_ec]);
                    w_cls_wd  = w_et;
                    w_push[w_ec] = 1'b1;
                end else begin
                    n_rsp.verdict   = V_FULL_DROP;
                    n_rsp.queue_sel = w_ec;
                    w_bump_en  = 1'b1;
                    w_bump_sel = CNT_CLASS_BASE + 3'(w_ec);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.cause_count = w_bump_en ? w_cnt_sat[w_bump_sel] : '0;
    end

    // Class queue memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_cls_we) begin
            r_cls_mem[w_cls_wa] <= w_cls_wd;
        end
        r_cls_rd <= r_cls_mem[w_cls_ra];
    end

    // Overflow queue memory holding class and tag.
    always_ff @(posedge i_clk) begin
        if (w_ovf_we) begin
            r_ovf_mem[w_ovf_wa] <= w_ovf_wd;
        end
        r_ovf_rd <= r_ovf_mem[w_ovf_ra];
    end

    // Sequencer state and the response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_q         <= Q_HIGH;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            if (w_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qpsq_checker.sv =====
// Port-level checks of the steering queues, bound to the top level.
// Depends on qpsq_pkg and the assertion macro header.
`default_nettype none

`include "qos_packet_steering_queues_macros.svh"

module qpsq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input qpsq_pkg::t_rsp    i_rsp_payload
);
    import qpsq_pkg::*;

    // A pending response is never withdrawn.
    `QPSQ_ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // Reset empties the response register.
    `QPSQ_ASSERT_NEXT_ANY(a_rsp_clear_after_reset, i_clk, !i_rst_n, !i_rsp_valid)

    // A request is only taken when the response register can take its result.
    `QPSQ_ASSERT_IMM(a_no_accept_over_rsp, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_rsp_valid || i_rsp_ready)

    // A forwarded packet reports its own class queue.
    `QPSQ_ASSERT_IMM(a_forward_queue, i_clk, i_rst_n, i_rsp_valid && (i_rsp_payload.verdict == V_FORWARDED), i_rsp_payload.queue_sel == i_rsp_payload.class_out)

    // A no-op result carries no other information.
    `QPSQ_ASSERT_IMM(a_none_clean, i_clk, i_rst_n, i_rsp_valid && (i_rsp_payload.verdict == V_NONE), (i_rsp_payload.queue_sel == '0) && (i_rsp_payload.tag_out == '0) && (i_rsp_payload.class_out == '0) && (i_rsp_payload.cause_count == '0))

endmodule

bind qos_packet_steering_queues qpsq_checker u_qpsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);

`default_nettype wire
